>>> hdl/u8sd_pkg.sv
`default_nettype none

package u8sd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CpW    = 21;
    localparam int unsigned CountW = 2;
    localparam int unsigned ContW  = 6;

    // Lead byte classes
    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_SKIP
    } t_lead;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           code_point_valid;
        logic           string_done;
    } t_out_item;

    typedef struct packed {
        logic [CountW-1:0] pending_count;
        logic [CpW-1:0]    partial_value;
    } t_dec_state;

endpackage

`default_nettype wire

>>> hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte per item in, one result item per byte out.
// An item is taken into an input register, decoded by a short shift-and-or
// step against the pending continuation count and partial code point, and
// the result lands in an output register. A result is offered once its item
// has moved from the input register into the output register. One item is
// accepted every cycle while the output
// side keeps taking results. A result flags whether its byte completed a code
// point (code_point is zero otherwise) and echoes the end-of-string flag.
// Continuation bytes are not checked, overlong forms and surrogates are
// passed, stray continuations and bytes F8-FF are skipped, and a sequence
// left incomplete at end of string is dropped.
`default_nettype none

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    // input channel
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  wire t_in_item  i_in_item,
    // result channel
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_item
);

    // input register
    logic       r_s1_valid;
    t_in_item   r_s1_item;
    // decoder state, updated when an item moves into the output register
    t_dec_state r_state;
    t_dec_state n_state;
    // output register
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;

    logic out_load;   // output register free to take a new item
    logic s1_adv;     // input register item moves on this cycle
    logic in_acc;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_load;
    // input register frees up when empty or when its item moves on
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_acc     = i_in_valid && !o_in_stall;

    u8sd_step u_step (
        .i_item   (r_s1_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

>>> hdl/u8sd_step.sv
`default_nettype none

// One decode step: current state plus one byte gives next state and result.
module u8sd_step
    import u8sd_pkg::*;
(
    input  wire t_in_item   i_item,
    input  wire t_dec_state i_state,
    output t_dec_state      o_state,
    output t_out_item       o_result
);

    t_lead            lead;
    logic [ByteW-1:0] b;
    logic [CpW-1:0]   shifted;

    assign b       = i_item.data_byte;
    assign shifted = {i_state.partial_value[CpW-ContW-1:0], b[ContW-1:0]};

    always_comb begin
        if (b[7] == 1'b0) begin
            lead = LEAD_ASCII;
        end else if (b[7:5] == 3'b110) begin
            lead = LEAD_TWO;
        end else if (b[7:4] == 4'b1110) begin
            lead = LEAD_THREE;
        end else if (b[7:3] == 5'b11110) begin
            lead = LEAD_FOUR;
        end else begin
            lead = LEAD_SKIP;
        end
    end

    always_comb begin
        o_state                   = i_state;
        o_result.code_point       = '0;
        o_result.code_point_valid = 1'b0;
        o_result.string_done      = i_item.end_of_string;

        if (i_state.pending_count != '0) begin
            // any byte counts as a continuation here
            o_state.pending_count = i_state.pending_count - CountW'(1);
            o_state.partial_value = shifted;
            if (i_state.pending_count == CountW'(1)) begin
                o_result.code_point       = shifted;
                o_result.code_point_valid = 1'b1;
                o_state.partial_value     = '0;
            end
        end else begin
            unique case (lead)
                LEAD_ASCII: begin
                    o_result.code_point       = CpW'(b);
                    o_result.code_point_valid = 1'b1;
                end
                LEAD_TWO: begin
                    o_state.partial_value = CpW'(b[4:0]);
                    o_state.pending_count = CountW'(1);
                end
                LEAD_THREE: begin
                    o_state.partial_value = CpW'(b[3:0]);
                    o_state.pending_count = CountW'(2);
                end
                LEAD_FOUR: begin
                    o_state.partial_value = CpW'(b[2:0]);
                    o_state.pending_count = CountW'(3);
                end
                default: begin
                    // stray continuation or invalid lead: skipped
                end
            endcase
        end

        if (i_item.end_of_string) begin
            o_state = '0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/u8sd_checker.sv
`default_nettype none

module u8sd_checker
    import u8sd_pkg::*;
(
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_stall,
    input wire t_in_item  i_in_item,
    input wire            o_out_valid,
    input wire            i_out_stall,
    input wire t_out_item o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed under stall");

    // no code point without the valid flag
    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.code_point_valid |-> o_out_item.code_point == '0)
        else $error("code point set without valid flag");

    // input side only stalls when the result side is backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with result side free");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an item accepted while the result side is not stalled is followed by o_out_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall) |=> ##1 o_out_valid)
        else $error("accepted item lost");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);

`default_nettype wire

>>> test/utf8_decode_checker.sv
`timescale 1ns / 1ps

module utf8_decode_checker
    import u8sd_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire            i_out_valid,
    input  wire            i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_outstanding,
    output int             o_result_count,
    output int             o_code_point_count
);

    // decoder state as the predictor sees it
    logic [CountW-1:0] cont_left;
    logic [CpW-1:0]    cp_gather;
    // expected results in order, indexed by running write and read counts
    t_out_item         expected_results[int];
    int                wr_idx;
    int                rd_idx;

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        $display("[%0t] mismatch: %s expected %0h got %0h", $time, what, want_v, got_v);
        o_fail_count++;
    endtask

    // one byte in, one result out; updates the gathered code point
    function automatic t_out_item predict_result(input t_in_item item);
        t_out_item        res;
        logic [ByteW-1:0] b;
        res = '0;
        b   = item.data_byte;
        if (cont_left != '0) begin
            // any byte counts as a continuation here, low six bits only
            cp_gather = {cp_gather[CpW-ContW-1:0], b[ContW-1:0]};
            cont_left = cont_left - CountW'(1);
            if (cont_left == '0) begin
                res.code_point       = cp_gather;
                res.code_point_valid = 1'b1;
                cp_gather            = '0;
            end
        end else begin
            casez (b)
                8'b0???????: begin
                    res.code_point       = CpW'(b);
                    res.code_point_valid = 1'b1;
                end
                8'b110?????: begin
                    cp_gather = CpW'(b[4:0]);
                    cont_left = 2'd1;
                end
                8'b1110????: begin
                    cp_gather = CpW'(b[3:0]);
                    cont_left = 2'd2;
                end
                8'b11110???: begin
                    cp_gather = CpW'(b[2:0]);
                    cont_left = 2'd3;
                end
                default: ; // stray continuation or F8-FF
            endcase
        end
        if (item.end_of_string) begin
            cont_left = '0;
            cp_gather = '0;
        end
        res.string_done = item.end_of_string;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_out_item want;
        if (!i_rst_n) begin
            expected_results.delete();
            wr_idx        = 0;
            rd_idx        = 0;
            cont_left     = '0;
            cp_gather     = '0;
            o_outstanding <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_results[wr_idx] = predict_result(i_in_item);
                wr_idx++;
            end
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (i_out_item.code_point_valid) begin
                    o_code_point_count++;
                end
                if (wr_idx == rd_idx) begin
                    report_mismatch("result with nothing pending", 0,
                                    32'(i_out_item.code_point));
                end else begin
                    want = expected_results[rd_idx];
                    expected_results.delete(rd_idx);
                    rd_idx++;
                    if (i_out_item.code_point !== want.code_point) begin
                        report_mismatch("code_point", 32'(want.code_point),
                                        32'(i_out_item.code_point));
                    end
                    if (i_out_item.code_point_valid !== want.code_point_valid) begin
                        report_mismatch("code_point_valid", 32'(want.code_point_valid),
                                        32'(i_out_item.code_point_valid));
                    end
                    if (i_out_item.string_done !== want.string_done) begin
                        report_mismatch("string_done", 32'(want.string_done),
                                        32'(i_out_item.string_done));
                    end
                end
            end
            o_outstanding <= wr_idx - rd_idx;
        end
    end

endmodule

>>> test/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
    import u8sd_pkg::*;

    // cycles with no handshake on either side before the run is abandoned;
    // worst honest case is a long sender gap plus a long receiver stall
    localparam int IdleLimit   = 3000;
    // minimum bytes sent over the whole run, directed ones included
    localparam int RandomBytes = 800;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int fail_count;
    int outstanding;
    int result_count;
    int code_point_count;

    int  bytes_sent     = 0;
    int  directed_bytes = 0;
    int  seq_bytes      = 0;
    // when set, neither side idles: gives stretches of back-to-back items
    bit  no_idle        = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    utf8_stream_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    utf8_decode_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_in_item          (in_item),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_out_item         (out_item),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding),
        .o_result_count     (result_count),
        .o_code_point_count (code_point_count)
    );

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte after a random gap and hold it until taken.
    // Valid stays high across back-to-back items, so it is never dropped and
    // raised again within one step.
    task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
        t_in_item item;
        int       gap;
        item.data_byte     = b;
        item.end_of_string = last;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // A structurally correct sequence of nbytes with random payload bits
    // (overlongs and surrogates included). Only the first 'upto' bytes go out;
    // 'last' marks the final one sent, so upto < nbytes truncates the string.
    task automatic send_code_point(input int nbytes, input int upto, input logic last);
        logic [ByteW-1:0] seq[4];
        logic [31:0]      r;
        r = $urandom;
        case (nbytes)
            1:       seq[0] = {1'b0, r[6:0]};
            2:       seq[0] = {3'b110, r[4:0]};
            3:       seq[0] = {4'b1110, r[3:0]};
            default: seq[0] = {5'b11110, r[2:0]};
        endcase
        for (int i = 1; i < 4; i++) begin
            r      = $urandom;
            seq[i] = {2'b10, r[5:0]};
        end
        for (int i = 0; i < upto; i++) begin
            send_byte(seq[i], last && (i == upto - 1));
        end
        seq_bytes += upto;
    endtask

    // Result side: runs of taking items broken by random stalls.
    initial begin : stall_gen
        int n;
        forever begin
            repeat ($urandom_range(1, 12)) @(posedge clk);
            n = idle_len();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IdleLimit) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no handshake for %0d cycles", IdleLimit);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int          pick;
        int          len;
        int          next_switch;
        logic [31:0] r;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed strings ----
        // ASCII extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // two-, three- and four-byte sequences
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // largest value a four-byte lead can carry, completed on the end flag
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // stray continuations and invalid leads are skipped
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        // ASCII taken as a continuation without checking
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // string ends mid-sequence: partial value dropped
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // end flag on a bare lead byte
        send_byte(8'hF4, 1'b1);
        directed_bytes = bytes_sent;

        // ---- random strings ----
        // mostly well-formed sequences, some truncated, the rest raw noise
        // that lands as stray bytes, broken sequences or odd continuations
        next_switch = 0;
        while (bytes_sent < RandomBytes) begin
            if (seq_bytes >= next_switch) begin
                no_idle      = ($urandom_range(0, 3) == 0);
                next_switch += 60;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                len = $urandom_range(1, 4);
                if (pick < 8 && len > 1) begin
                    send_code_point(len, $urandom_range(1, len - 1), 1'b1);
                end else begin
                    send_code_point(len, len, $urandom_range(0, 5) == 0);
                end
            end else begin
                r = $urandom;
                send_byte(r[7:0], $urandom_range(0, 4) == 0);
            end
        end
        in_valid <= 1'b0;

        // drain: step past the current edge first so the last accept has reached the checker
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);

        $display("Fed %0d bytes (%0d directed); checked %0d results, %0d complete code points",
                 bytes_sent, directed_bytes, result_count, code_point_count);
        $display("Strings mixed ASCII, 2-4 byte sequences, stray and invalid bytes, "
                 , "unchecked continuations and truncated endings");
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> utf8_stream_decoder.f
hdl/u8sd_pkg.sv
hdl/u8sd_step.sv
hdl/utf8_stream_decoder.sv
hdl/u8sd_checker.sv
test/utf8_decode_checker.sv
test/tb_utf8_stream_decoder.sv
